// File: hdl/jakc_pkg.sv
`default_nettype none

package jakc_pkg;

    // item and state widths
    localparam int ADC_W        = 12;
    localparam int EST_W        = 20;
    localparam int EST_FRAC     = 8;
    localparam int VAR_W        = 32;
    localparam int K_BITS       = 17;
    localparam int CNT_W        = 5;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 14;
    localparam int VAL_W        = 14;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;
    localparam int APB_AW       = 5;
    localparam int APB_DW       = 32;
    localparam int PULSE_LIMIT  = 3000;

    // parameter defaults
    localparam int PULSE_MAX_DEF    = 2000;
    localparam int PULSE_MIN_DEF    = 1000;
    localparam int PULSE_CENTER_DEF = 1500;
    localparam int ADC_BITS_DEF     = 12;

    // register map, index = paddr[4:2]
    localparam logic [2:0] RI_ZERO_POINT   = 3'd0;
    localparam logic [2:0] RI_PROC_NOISE   = 3'd1;
    localparam logic [2:0] RI_MEAS_NOISE   = 3'd2;
    localparam logic [2:0] RI_INIT_VAR     = 3'd3;
    localparam logic [2:0] RI_DEAD_ZONE    = 3'd4;
    localparam logic [2:0] RI_AXIS_GAIN    = 3'd5;
    localparam logic [2:0] RI_INVERT       = 3'd6;

    // register reset values
    localparam logic [ADC_W-1:0]  ZERO_POINT_RST = 12'd2048;
    localparam logic [VAR_W-1:0]  NOISE_RST      = 32'd65536;
    localparam logic [VAR_W-1:0]  INIT_VAR_RST   = 32'd65536;
    localparam logic [ADC_W-1:0]  DEAD_ZONE_RST  = 12'd0;
    localparam logic [GAIN_W-1:0] AXIS_GAIN_RST  = 16'h4000;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PREP = 9'b000000010,
        ST_DIV  = 9'b000000100,
        ST_UPD  = 9'b000001000,
        ST_OFS  = 9'b000010000,
        ST_GAIN = 9'b000100000,
        ST_MAP  = 9'b001000000,
        ST_DIVC = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// File: hdl/joystick_axis_kalman_conditioner.sv
`default_nettype none

// channel  direction  beat
// s_axis   in         raw_sample
// m_axis   out        pulse_value, filtered_sample
// apb      in/out     register writes and reads, 7 registers at 4*index
//
// a new sample is accepted only in idle, once the previous item has been through all steps; DM_W is
// the bit width of |PULSE_MAX - PULSE_MIN|, at least 2
// the work is done by the 17-step serial gain divider with its trailing serial multiply
// and by the DM_W-step serial divider of the pulse mapping
// reset is asynchronous: registers take their defaults and the filter state is reloaded
// a finished result waits in the output register while the next sample is accepted;
// the block only holds a second result back while that register is still full

module joystick_axis_kalman_conditioner #(
    parameter int PULSE_MAX    = jakc_pkg::PULSE_MAX_DEF,
    parameter int PULSE_MIN    = jakc_pkg::PULSE_MIN_DEF,
    parameter int PULSE_CENTER = jakc_pkg::PULSE_CENTER_DEF,
    parameter int ADC_BITS     = jakc_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [jakc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // raw_sample[11:0], zero pad
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [jakc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // pulse_value[11:0],
                                                                // filtered_sample[23:12]
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jakc_pkg::APB_AW-1:0]         paddr,
    input  logic [jakc_pkg::APB_DW-1:0]         pwdata,
    output logic [jakc_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import jakc_pkg::*;

    localparam int  DIFF_RAW = PULSE_MAX - PULSE_MIN;
    localparam bit  DIFF_NEG = (DIFF_RAW < 0);
    localparam int  DIFF_MAG = DIFF_NEG ? -DIFF_RAW : DIFF_RAW;
    localparam int  DIVISOR  = 2 * PULSE_MAX;
    localparam int  OFF_W    = $clog2(PULSE_MAX + 1);
    localparam int  Q1_W     = OFF_W + 1;
    localparam int  DM_W     = ($clog2(DIFF_MAG + 1) < 2) ? 2 : $clog2(DIFF_MAG + 1);
    localparam int  N_W      = Q1_W + DM_W;
    localparam int  RW       = $clog2(DIVISOR);
    localparam int  GP_W     = OFF_W + GAIN_W;
    localparam logic [ADC_W-1:0] RAW_MASK =
        (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [ADC_W-1:0]       zp_reg, zp_next;
    logic [VAR_W-1:0]       qn_reg, qn_next;
    logic [VAR_W-1:0]       rn_reg, rn_next;
    logic [VAR_W-1:0]       iv_reg, iv_next;
    logic [ADC_W-1:0]       dz_reg, dz_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic                   inv_reg, inv_next;

    logic [EST_W-1:0]       est_reg, est_next;
    logic [VAR_W-1:0]       var_reg, var_next;

    logic                   qbit_reg, qbit_next;
    logic                   mul_on_reg, mul_on_next;
    logic                   out_valid_reg, out_valid_next;

    logic [VAR_W-1:0]       p1_reg, p1_next;
    logic [VAR_W:0]         denom_reg, denom_next;
    logic                   dzero_reg, dzero_next;
    logic [VAR_W:0]         rem_reg, rem_next;
    logic [EST_W-1:0]       dmag_reg, dmag_next;
    logic                   dneg_reg, dneg_next;
    logic [35:0]            ae_reg, ae_next;
    logic [47:0]            ap_reg, ap_next;
    logic [OFF_W-1:0]       mag_reg, mag_next;
    logic                   sgn_reg, sgn_next;
    logic [GP_W-1:0]        gp_reg, gp_next;
    logic [RW-1:0]          crem_reg, crem_next;
    logic [DM_W-1:0]        nlow_reg, nlow_next;
    logic [ADC_W-1:0]       out_pulse_reg, out_pulse_next;
    logic [ADC_W-1:0]       out_filt_reg, out_filt_next;

    logic                   cfg_wr;
    logic [2:0]             cfg_idx;
    logic                   reload;

    logic [ADC_W-1:0]       raw;
    logic [EST_W-1:0]       raw_q;
    logic [VAR_W:0]         p1_sum;
    logic [VAR_W+1:0]       t_div;
    logic                   qb;
    logic [EST_W-1:0]       delta;
    logic [47:0]            var_diff;
    logic [ADC_W-1:0]       filt;
    logic [ADC_W:0]         offs;
    logic [ADC_W-1:0]       amag;
    logic [ADC_W-1:0]       cmag;
    logic [GAIN_W-1:0]      gmag;
    logic [Q1_W-1:0]        q1;
    logic [N_W-1:0]         nv;
    logic [RW:0]            t_map;
    logic                   qm;
    logic signed [VAL_W-1:0] val0, val1, qv;

    assign cfg_wr        = psel & penable & pwrite & pready;
    assign cfg_idx       = paddr[4:2];
    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_filt_reg, out_pulse_reg};

    always_comb
    begin
        unique case (cfg_idx)
            RI_ZERO_POINT: prdata = {{(APB_DW-ADC_W){1'b0}}, zp_reg};
            RI_PROC_NOISE: prdata = qn_reg;
            RI_MEAS_NOISE: prdata = rn_reg;
            RI_INIT_VAR:   prdata = iv_reg;
            RI_DEAD_ZONE:  prdata = {{(APB_DW-ADC_W){1'b0}}, dz_reg};
            RI_AXIS_GAIN:  prdata = {{(APB_DW-GAIN_W){1'b0}}, gain_reg};
            RI_INVERT:     prdata = {{(APB_DW-1){1'b0}}, inv_reg};
            default:       prdata = '0;
        endcase
    end

    // datapath helpers
    always_comb
    begin
        raw      = s_axis_tdata[ADC_W-1:0] & RAW_MASK;
        raw_q    = {raw, {EST_FRAC{1'b0}}};
        p1_sum   = {1'b0, var_reg} + {1'b0, qn_reg};

        t_div    = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        qb       = (t_div >= {1'b0, denom_reg});

        delta    = ae_reg[35:16];
        var_diff = {p1_reg, 16'h0000} - ap_reg;

        filt     = est_reg[EST_W-1:EST_FRAC];
        offs     = {1'b0, filt} - {1'b0, zp_reg};
        amag     = offs[ADC_W] ? ADC_W'(-offs) : offs[ADC_W-1:0];
        if (amag < dz_reg)
            cmag = '0;
        else if (amag > ADC_W'(PULSE_MAX))
            cmag = ADC_W'(PULSE_MAX);
        else
            cmag = amag;

        gmag     = gain_reg[GAIN_W-1] ? (~gain_reg + 1'b1) : gain_reg;

        q1       = Q1_W'(gp_reg >> GAIN_FRAC);
        nv       = {{DM_W{1'b0}}, q1} * N_W'(DIFF_MAG);

        t_map    = {crem_reg, nlow_reg[DM_W-1]};
        qm       = (t_map >= (RW+1)'(DIVISOR));

        qv       = VAL_W'({{(VAL_W-DM_W){1'b0}}, nlow_reg});
        val0     = sgn_reg ? (VAL_W'(PULSE_CENTER) - qv) : (VAL_W'(PULSE_CENTER) + qv);
        val1     = inv_reg ? (VAL_W'(PULSE_LIMIT) - val0) : val0;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        zp_next        = zp_reg;
        qn_next        = qn_reg;
        rn_next        = rn_reg;
        iv_next        = iv_reg;
        dz_next        = dz_reg;
        gain_next      = gain_reg;
        inv_next       = inv_reg;
        est_next       = est_reg;
        var_next       = var_reg;
        qbit_next      = qbit_reg;
        mul_on_next    = mul_on_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        p1_next        = p1_reg;
        denom_next     = denom_reg;
        dzero_next     = dzero_reg;
        rem_next       = rem_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        ae_next        = ae_reg;
        ap_next        = ap_reg;
        mag_next       = mag_reg;
        sgn_next       = sgn_reg;
        gp_next        = gp_reg;
        crem_next      = crem_reg;
        nlow_next      = nlow_reg;
        out_pulse_next = out_pulse_reg;
        out_filt_next  = out_filt_reg;
        reload         = 1'b0;

        if (cfg_wr)
        begin
            reload = 1'b1;
            unique case (cfg_idx)
                RI_ZERO_POINT: zp_next   = pwdata[ADC_W-1:0];
                RI_PROC_NOISE: qn_next   = pwdata;
                RI_MEAS_NOISE: rn_next   = pwdata;
                RI_INIT_VAR:   iv_next   = pwdata;
                RI_DEAD_ZONE:  dz_next   = pwdata[ADC_W-1:0];
                RI_AXIS_GAIN:  gain_next = pwdata[GAIN_W-1:0];
                RI_INVERT:     inv_next  = pwdata[0];
                default:       reload    = 1'b0;
            endcase
            if (reload)
            begin
                est_next = {zp_next, {EST_FRAC{1'b0}}};
                var_next = iv_next;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    p1_next    = p1_sum[VAR_W] ? {VAR_W{1'b1}} : p1_sum[VAR_W-1:0];
                    dneg_next  = (est_reg > raw_q);
                    dmag_next  = (est_reg > raw_q) ? (est_reg - raw_q) : (raw_q - est_reg);
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                denom_next  = {1'b0, p1_reg} + {1'b0, rn_reg};
                dzero_next  = (({1'b0, p1_reg} + {1'b0, rn_reg}) == '0);
                rem_next    = {1'b0, p1_reg};
                ae_next     = '0;
                ap_next     = '0;
                cnt_next    = '0;
                mul_on_next = 1'b0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring divide, one gain bit a cycle, msb first
                if (cnt_reg < CNT_W'(K_BITS))
                begin
                    rem_next    = qb ? (VAR_W+1)'(t_div - {1'b0, denom_reg}) : t_div[VAR_W:0];
                    qbit_next   = qb & ~dzero_reg;
                    mul_on_next = 1'b1;
                end
                else
                begin
                    mul_on_next = 1'b0;
                end
                // shift-add multiply takes each gain bit in the cycle after the divider makes it
                if (mul_on_reg)
                begin
                    ae_next = {ae_reg[34:0], 1'b0} + (qbit_reg ? {16'h0000, dmag_reg} : '0);
                    ap_next = {ap_reg[46:0], 1'b0} + (qbit_reg ? {16'h0000, p1_reg} : '0);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(K_BITS))
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                est_next   = dneg_reg ? (est_reg - delta) : (est_reg + delta);
                var_next   = var_diff[47:16];
                state_next = ST_OFS;
            end
            ST_OFS:
            begin
                mag_next   = OFF_W'(cmag);
                sgn_next   = offs[ADC_W];
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                gp_next    = {{GAIN_W{1'b0}}, mag_reg} * {{OFF_W{1'b0}}, gmag};
                sgn_next   = sgn_reg ^ gain_reg[GAIN_W-1];
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                crem_next  = RW'(nv >> DM_W);
                nlow_next  = nv[DM_W-1:0];
                sgn_next   = sgn_reg ^ DIFF_NEG;
                cnt_next   = '0;
                state_next = ST_DIVC;
            end
            ST_DIVC:
            begin
                // quotient bits shift in where dividend bits shift out
                crem_next = qm ? RW'(t_map - (RW+1)'(DIVISOR)) : t_map[RW-1:0];
                nlow_next = {nlow_reg[DM_W-2:0], qm};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DM_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (val1 < 0)
                        out_pulse_next = '0;
                    else if (val1 > VAL_W'(PULSE_LIMIT))
                        out_pulse_next = ADC_W'(PULSE_LIMIT);
                    else
                        out_pulse_next = val1[ADC_W-1:0];
                    out_filt_next  = filt;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            zp_reg        <= ZERO_POINT_RST;
            qn_reg        <= NOISE_RST;
            rn_reg        <= NOISE_RST;
            iv_reg        <= INIT_VAR_RST;
            dz_reg        <= DEAD_ZONE_RST;
            gain_reg      <= AXIS_GAIN_RST;
            inv_reg       <= 1'b0;
            est_reg       <= {ZERO_POINT_RST, {EST_FRAC{1'b0}}};
            var_reg       <= INIT_VAR_RST;
            qbit_reg      <= 1'b0;
            mul_on_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            zp_reg        <= zp_next;
            qn_reg        <= qn_next;
            rn_reg        <= rn_next;
            iv_reg        <= iv_next;
            dz_reg        <= dz_next;
            gain_reg      <= gain_next;
            inv_reg       <= inv_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
            qbit_reg      <= qbit_next;
            mul_on_reg    <= mul_on_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg        <= p1_next;
        denom_reg     <= denom_next;
        dzero_reg     <= dzero_next;
        rem_reg       <= rem_next;
        dmag_reg      <= dmag_next;
        dneg_reg      <= dneg_next;
        ae_reg        <= ae_next;
        ap_reg        <= ap_next;
        mag_reg       <= mag_next;
        sgn_reg       <= sgn_next;
        gp_reg        <= gp_next;
        crem_reg      <= crem_next;
        nlow_reg      <= nlow_next;
        out_pulse_reg <= out_pulse_next;
        out_filt_reg  <= out_filt_next;
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(K_BITS)))
        else $error("gain divider ran past its last step");

    a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |=> (var_reg <= $past(p1_reg)))
        else $error("variance grew in the update");

    a_map_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVC) |-> (crem_reg < RW'(DIVISOR)))
        else $error("mapping remainder not below divisor");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (nlow_reg <= DM_W'(DIFF_MAG)))
        else $error("mapping quotient out of range");

    a_est_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(est_reg) |-> ($past(state_reg == ST_UPD) || $past(cfg_wr)))
        else $error("estimate changed outside update or reload");

endmodule

`default_nettype wire
